FILE: design/quadratic_drag_force_stream_assert.svh
// Assertion macros shared by the drag force stream modules.
// No dependencies.
`ifndef QUADRATIC_DRAG_FORCE_STREAM_ASSERT_SVH
`define QUADRATIC_DRAG_FORCE_STREAM_ASSERT_SVH
`ifndef ASSERT_OFF
`define QDF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define QDF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define QDF_ASSERT(label, clk, rst_n, prop)
`define QDF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/qdf_pkg.sv
// Types and constants shared by the drag force stream modules.
// No dependencies.
package qdf_pkg;
  localparam int MAX_DRONES = 16;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
    logic [15:0]        gain;
    logic [3:0]         drone;
    logic               payload;
    logic               last;
  } job_t;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic [3:0]         drone;
    logic               payload;
    logic               last;
  } res_t;

  localparam logic [1:0] REG_DRONE_GAIN   = 2'd0;
  localparam logic [1:0] REG_PAYLOAD_GAIN = 2'd1;
  localparam logic [1:0] REG_NUM_DRONES   = 2'd2;
  localparam logic [1:0] REG_DEAD_ZONE    = 2'd3;
endpackage

FILE: design/qdf_front.sv
// Front part: accepts wind words, keeps frame sums, and issues drag jobs.
// Depends on qdf_pkg. Frame average uses a restoring divider, one bit a cycle.
module qdf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [47:0]         in_tdata,
  input  logic [15:0]         drone_gain,
  input  logic [15:0]         payload_gain,
  input  logic [4:0]          frame_len,
  output logic                job_valid,
  input  logic                job_ready,
  output qdf_pkg::job_t       job
);
  import qdf_pkg::*;
  localparam int SW = 20;
  localparam int CW = (MAX_DRONES > 1) ? $clog2(MAX_DRONES) : 1;

  typedef enum logic [1:0] {S_IDLE, S_DRONE, S_DIV, S_PAY} st_t;
  st_t st_r;
  logic [CW-1:0] count_r;
  logic signed [SW-1:0] sx_r, sy_r, sz_r;
  logic signed [15:0] wx_r, wy_r, wz_r;
  logic done_r;
  logic [4:0] n_r;
  logic [1:0] axis_r;
  logic [4:0] bit_r;
  logic [SW:0] num_r;
  logic [SW:0] rem_r;
  logic [SW:0] quo_r;
  logic signed [SW-1:0] ax_r, ay_r;

  logic [4:0] n_eff;
  logic signed [SW-1:0] nsx, nsy, nsz;
  logic signed [SW-1:0] cur_sum;
  logic [SW:0] rem_sh, q_fin;
  logic signed [SW-1:0] q_sgn;

  always_comb begin
    if (frame_len == 5'd0) n_eff = 5'd1;
    else if (frame_len > 5'(MAX_DRONES)) n_eff = 5'(MAX_DRONES);
    else n_eff = frame_len;
    nsx = sx_r + SW'(signed'(in_tdata[15:0]));
    nsy = sy_r + SW'(signed'(in_tdata[31:16]));
    nsz = sz_r + SW'(signed'(in_tdata[47:32]));
    case (axis_r)
      2'd0: cur_sum = sx_r;
      2'd1: cur_sum = sy_r;
      default: cur_sum = sz_r;
    endcase
    rem_sh = {rem_r[SW-1:0], num_r[SW]};
    q_fin = quo_r;
    q_sgn = cur_sum[SW-1] ? -SW'(q_fin) : SW'(q_fin);
  end

  assign in_tready = (st_r == S_IDLE);
  assign job_valid = (st_r == S_DRONE) || (st_r == S_PAY);

  always_comb begin
    job = '0;
    if (st_r == S_DRONE) begin
      job.x = SW'(wx_r); job.y = SW'(wy_r); job.z = SW'(wz_r);
      job.gain = drone_gain;
      job.drone = 4'(count_r);
      job.last = !done_r;
    end else begin
      job.x = ax_r; job.y = ay_r; job.z = q_sgn;
      job.gain = payload_gain;
      job.payload = 1'b1;
      job.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      count_r <= '0;
      sx_r <= '0; sy_r <= '0; sz_r <= '0;
      done_r <= 1'b0;
      axis_r <= '0;
      bit_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: if (in_tvalid) begin
          wx_r <= in_tdata[15:0]; wy_r <= in_tdata[31:16]; wz_r <= in_tdata[47:32];
          sx_r <= nsx; sy_r <= nsy; sz_r <= nsz;
          n_r <= n_eff;
          done_r <= (5'(count_r) + 5'd1) >= n_eff;
          st_r <= S_DRONE;
        end
        S_DRONE: if (job_ready) begin
          if (done_r) begin
            st_r <= S_DIV;
            axis_r <= 2'd0;
            bit_r <= 5'd0;
            rem_r <= '0;
            quo_r <= '0;
            num_r <= (sx_r[SW-1] ? (SW+1)'(-sx_r) : {1'b0, sx_r}) + (SW+1)'(n_r >> 1);
            count_r <= '0;
          end else begin
            count_r <= count_r + 1'b1;
            st_r <= S_IDLE;
          end
        end
        S_DIV: begin
          if (rem_sh >= (SW+1)'(n_r)) begin
            rem_r <= rem_sh - (SW+1)'(n_r);
            quo_r <= {quo_r[SW-1:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[SW-1:0], 1'b0};
          end
          num_r <= {num_r[SW-1:0], 1'b0};
          bit_r <= bit_r + 5'd1;
          if (bit_r == 5'(SW + 1)) begin
            quo_r <= quo_r;
            if (axis_r == 2'd0) ax_r <= q_sgn;
            if (axis_r == 2'd1) ay_r <= q_sgn;
            if (axis_r == 2'd2) st_r <= S_PAY;
            else begin
              axis_r <= axis_r + 2'd1;
              bit_r <= 5'd0;
              rem_r <= '0;
              quo_r <= '0;
              num_r <= ((axis_r == 2'd0) ? (sy_r[SW-1] ? (SW+1)'(-sy_r) : {1'b0, sy_r})
                                          : (sz_r[SW-1] ? (SW+1)'(-sz_r) : {1'b0, sz_r}))
                       + (SW+1)'(n_r >> 1);
            end
          end
        end
        S_PAY: if (job_ready) begin
          sx_r <= '0; sy_r <= '0; sz_r <= '0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`include "quadratic_drag_force_stream_assert.svh"
  `QDF_ASSERT(a_count_bound, clk, rst_n, 32'(count_r) < MAX_DRONES)
  `QDF_ASSERT_IMPL(a_pay_last, clk, rst_n, st_r == S_PAY, job.last)
  `QDF_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, st_r != S_IDLE, !in_tready)
endmodule

FILE: design/qdf_fifo.sv
// Two-entry job queue between the front and back parts.
// Depends on qdf_pkg.
module qdf_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  qdf_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output qdf_pkg::job_t rd_data
);
  import qdf_pkg::*;
  job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr_fire, rd_fire;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data = mem_r[rp_r];
  assign wr_fire = wr_valid && wr_ready;
  assign rd_fire = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_fire) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr_fire) wp_r <= !wp_r;
      if (rd_fire) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr_fire} - {1'b0, rd_fire};
    end
  end

`include "quadratic_drag_force_stream_assert.svh"
  `QDF_ASSERT(a_cnt_max, clk, rst_n, cnt_r <= 2'd2)
  `QDF_ASSERT(a_ptr_eq, clk, rst_n, (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wp_r == rp_r))
  `QDF_ASSERT(a_ptr_ne, clk, rst_n, (cnt_r == 2'd1) |-> (wp_r != rp_r))
endmodule

FILE: design/qdf_back.sv
// Back part: square root, dead-zone test and per-axis force with saturation.
// Depends on qdf_pkg. Square root runs two bits a step; axes share one multiplier.
module qdf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  qdf_pkg::job_t job,
  input  logic [15:0]   dead_zone,
  output logic          out_tvalid,
  input  logic          out_tready,
  output qdf_pkg::res_t res
);
  import qdf_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_SQ, S_ROOT, S_MUL1, S_MUL2, S_OUT} st_t;
  st_t st_r;
  job_t j_r;
  logic [1:0] ax_r;
  logic [41:0] n_r;
  logic [41:0] res_r;
  logic [41:0] bit_r;
  logic [39:0] sq_r [3];
  logic [35:0] gs_r;
  logic [55:0] p_r;
  logic signed [31:0] f_r [3];
  logic zero_r;

  logic signed [19:0] c;
  logic [19:0] cm;
  logic [41:0] trial;
  logic [41:0] root_fin;
  logic [56:0] fr;
  logic [31:0] sat;

  always_comb begin
    case (ax_r)
      2'd0: c = j_r.x;
      2'd1: c = j_r.y;
      default: c = j_r.z;
    endcase
    cm = c[19] ? 20'(-c) : c;
    trial = res_r + bit_r;
    root_fin = (n_r >= trial) ? (res_r >> 1) + bit_r : res_r >> 1;
    fr = ({1'b0, p_r} + 57'h80000) >> 20;
    if (c[19]) sat = (fr > 57'h80000000) ? 32'h80000000 : 32'(-fr[31:0]);
    else sat = (fr > 57'h7FFFFFFF) ? 32'h7FFFFFFF : fr[31:0];
  end

  assign job_ready = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  always_comb begin
    res.fx = f_r[0]; res.fy = f_r[1]; res.fz = f_r[2];
    res.drone = j_r.drone; res.payload = j_r.payload; res.last = j_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: if (job_valid) begin
          j_r <= job;
          st_r <= S_SQ;
        end
        S_SQ: begin
          sq_r[0] <= 40'(j_r.x) * 40'(j_r.x);
          sq_r[1] <= 40'(j_r.y) * 40'(j_r.y);
          sq_r[2] <= 40'(j_r.z) * 40'(j_r.z);
          n_r <= '0;
          st_r <= S_ROOT;
          res_r <= '0;
          bit_r <= 42'h1 << 40;
        end
        S_ROOT: begin
          if (bit_r == (42'h1 << 40)) begin
            n_r <= {2'b0, sq_r[0]} + {2'b0, sq_r[1]} + {2'b0, sq_r[2]};
          end else begin
            if (n_r >= trial) begin
              n_r <= n_r - trial;
              res_r <= (res_r >> 1) + bit_r;
            end else res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r == 42'h1) begin
            zero_r <= (root_fin <= {26'd0, dead_zone});
            gs_r <= 36'(j_r.gain) * 36'(root_fin);
            ax_r <= 2'd0;
            st_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          p_r <= 56'(gs_r) * 56'(cm);
          st_r <= S_MUL2;
        end
        S_MUL2: begin
          f_r[ax_r] <= zero_r ? 32'd0 : sat;
          if (ax_r == 2'd2) st_r <= S_OUT;
          else begin
            ax_r <= ax_r + 2'd1;
            st_r <= S_MUL1;
          end
        end
        S_OUT: if (out_tready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

`include "quadratic_drag_force_stream_assert.svh"
  `QDF_ASSERT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> out_tvalid)
  `QDF_ASSERT_IMPL(a_busy, clk, rst_n, st_r != S_IDLE, !job_ready)
  `QDF_ASSERT_IMPL(a_axis, clk, rst_n, st_r == S_MUL1, ax_r != 2'd3)
endmodule

FILE: design/quadratic_drag_force_stream.sv
// Channel | dir | tdata fields (low bit up)                 | tuser      | tlast
// in      | in  | wind_x, wind_y, wind_z                    | -          | -
// out     | out | force_x, force_y, force_z, drone_number   | is_payload | last
// A drone word holds the back part for 21 square-root steps, six multiply
// steps and the handshakes. The word that closes a frame holds the front
// for 22 divider steps per payload axis.
// Reset is synchronous; configuration clears to its defaults.
// Either side may stall; the job queue holds up to two pending jobs.
module quadratic_drag_force_stream (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // wind_x, wind_y, wind_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // force_x, force_y, force_z, drone_number, pad
  output logic         out_tuser,  // is_payload
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import qdf_pkg::*;
  logic [15:0] dg_r, pg_r, dz_r;
  logic [4:0] nd_r;
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  job_t fj, bj;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dg_r <= '0; pg_r <= '0; nd_r <= 5'd1; dz_r <= 16'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DRONE_GAIN:   dg_r <= cfg_data;
        REG_PAYLOAD_GAIN: pg_r <= cfg_data;
        REG_NUM_DRONES:   nd_r <= cfg_data[4:0];
        REG_DEAD_ZONE:    dz_r <= cfg_data;
        default: ;
      endcase
    end
  end

  qdf_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .drone_gain(dg_r), .payload_gain(pg_r), .frame_len(nd_r),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj));

  qdf_fifo u_fifo (
    .clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj));

  qdf_back u_back (
    .clk, .rst_n, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .dead_zone(dz_r), .out_tvalid, .out_tready, .res);

  assign out_tdata = {4'd0, res.drone, res.fz, res.fy, res.fx};
  assign out_tuser = res.payload;
  assign out_tlast = res.last;
endmodule

FILE: dv/qdf_checker.sv
// Checker for the drag force stream: watches the input, output and config ports,
// predicts each result word and compares it field by field.
// Depends on qdf_pkg for the register index constants.
`timescale 1ns / 1ps
module qdf_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [47:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [103:0] out_tdata,
  input  logic         out_tuser,
  input  logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output int           fail_count,
  output int           pending_forces
);
  import qdf_pkg::*;

  typedef struct {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic [3:0]         drone;
    logic               payload;
    logic               last;
  } force_t;

  force_t force_q[$];
  logic [15:0] drone_gain_r, payload_gain_r, dead_zone_r;
  logic [4:0]  frame_len_r;
  logic [3:0]  drone_cnt;
  int          acc_x, acc_y, acc_z;

  assign pending_forces = force_q.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, rem, bitv;
    root = 0;
    rem = v;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic signed [31:0] axis_drag(logic [15:0] gain, longint unsigned speed,
                                                  int c);
    longint unsigned mag, prod, f;
    mag = (c < 0) ? longint'(-c) : longint'(c);
    prod = longint'(gain) * speed * mag;
    f = (prod + (64'd1 << 19)) >> 20;
    if (c < 0) begin
      if (f > 64'h8000_0000) f = 64'h8000_0000;
      return -f[31:0];
    end
    if (f > 64'h7FFF_FFFF) f = 64'h7FFF_FFFF;
    return f[31:0];
  endfunction

  function automatic force_t drag_force(logic [15:0] gain, int x, int y, int z);
    force_t r;
    longint unsigned sq, speed;
    sq = longint'(x) * x + longint'(y) * y + longint'(z) * z;
    speed = int_sqrt(sq);
    r = '{default: '0};
    if (speed > dead_zone_r) begin
      r.fx = axis_drag(gain, speed, x);
      r.fy = axis_drag(gain, speed, y);
      r.fz = axis_drag(gain, speed, z);
    end
    return r;
  endfunction

  function automatic int wind_mean(int s, int n);
    int m, q;
    m = (s < 0) ? -s : s;
    q = (m + n / 2) / n;
    return (s < 0) ? -q : q;
  endfunction

  task automatic predict_word(logic [47:0] d);
    int x, y, z, n;
    force_t fd, fp;
    x = $signed(d[15:0]);
    y = $signed(d[31:16]);
    z = $signed(d[47:32]);
    n = frame_len_r;
    if (n < 1) n = 1;
    if (n > MAX_DRONES) n = MAX_DRONES;
    fd = drag_force(drone_gain_r, x, y, z);
    fd.drone = drone_cnt;
    fd.payload = 1'b0;
    acc_x += x;
    acc_y += y;
    acc_z += z;
    if (int'(drone_cnt) + 1 < n) begin
      fd.last = 1'b1;
      force_q = {force_q, fd};
      drone_cnt++;
    end else begin
      fd.last = 1'b0;
      force_q = {force_q, fd};
      fp = drag_force(payload_gain_r, wind_mean(acc_x, n), wind_mean(acc_y, n),
                      wind_mean(acc_z, n));
      fp.drone = 4'd0;
      fp.payload = 1'b1;
      fp.last = 1'b1;
      force_q = {force_q, fp};
      drone_cnt = 0;
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
    end
  endtask

  task automatic compare_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s expected %0d actual %0d", name, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    force_t e;
    if (!rst_n) begin
      drone_gain_r <= 16'd0;
      payload_gain_r <= 16'd0;
      frame_len_r <= 5'd1;
      dead_zone_r <= 16'd2;
      drone_cnt = 0;
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DRONE_GAIN:   drone_gain_r <= cfg_data;
          REG_PAYLOAD_GAIN: payload_gain_r <= cfg_data;
          REG_NUM_DRONES:   frame_len_r <= cfg_data[4:0];
          REG_DEAD_ZONE:    dead_zone_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_word(in_tdata);
      if (out_tvalid && out_tready) begin
        if (force_q.size() == 0) begin
          $error("unexpected result word");
          fail_count++;
        end else begin
          e = force_q.pop_front();
          compare_field("force_x", e.fx, $signed(out_tdata[31:0]));
          compare_field("force_y", e.fy, $signed(out_tdata[63:32]));
          compare_field("force_z", e.fz, $signed(out_tdata[95:64]));
          compare_field("drone_number", e.drone, out_tdata[99:96]);
          compare_field("is_payload", e.payload, out_tuser);
          compare_field("last", e.last, out_tlast);
        end
      end
    end
  end
endmodule

FILE: dv/tb_quadratic_drag_force_stream.sv
// Testbench top for the drag force stream: drives wind words and register
// writes through several settings; qdf_checker predicts and compares results.
// Depends on qdf_pkg, quadratic_drag_force_stream and qdf_checker.
`timescale 1ns / 1ps
module tb_quadratic_drag_force_stream;
  import qdf_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = REG_DRONE_GAIN;
  logic [15:0]  cfg_data = '0;
  int           fail_count;
  int           pending_forces;
  int           cycle_count = 0;

  always #1 clk = ~clk;

  quadratic_drag_force_stream u_dut (.*);

  qdf_checker u_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("tb_quadratic_drag_force_stream NOT OK");
      $finish;
    end
  end

  // Result side stalls at random, with stretches of no stalling.
  always @(posedge clk) begin
    int hold;
    if (hold > 0) begin
      out_tready <= 1'b0;
      hold--;
    end else begin
      out_tready <= 1'b1;
      if (out_tvalid && out_tready)
        hold = ((cycle_count / 3000) % 3 == 1) ? 0 : $urandom_range(0, 19);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_wind(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_forces != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_axis(int mode);
    case (mode)
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($signed($urandom_range(0, 2047)) - 1024);
      2: return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(0, 15)) - 8);
    endcase
  endfunction

  initial begin
    int mode;
    bit fast;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, then extremes of the fields.
    send_wind(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
    drain();
    write_reg(REG_DRONE_GAIN, 16'hFFFF);
    write_reg(REG_PAYLOAD_GAIN, 16'hFFFF);
    write_reg(REG_NUM_DRONES, 16'd3);
    write_reg(REG_DEAD_ZONE, 16'd0);
    send_wind(-16'sd32768, -16'sd32768, -16'sd32768, 0);
    send_wind(16'sh7FFF, -16'sd32768, 16'sd0, 0);
    send_wind(16'sd0, 16'sd0, 16'sd0, 0);
    send_wind(16'sd1, -16'sd1, 16'sd0, 0);
    send_wind(16'sd2, 16'sd0, 16'sd0, 1);
    send_wind(-16'sd3, 16'sd0, 16'sd1, 1);
    drain();
    // Dead zone at its top: no speed gets through, even the biggest.
    write_reg(REG_DEAD_ZONE, 16'hFFFF);
    write_reg(REG_NUM_DRONES, 16'd0);
    send_wind(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
    send_wind(16'sh4000, 16'sh4000, 16'sd0, 0);
    drain();
    // Frame length lowered mid-frame, then beyond the maximum.
    write_reg(REG_DEAD_ZONE, 16'd2);
    write_reg(REG_NUM_DRONES, 16'd16);
    repeat (5) send_wind(16'sd300, -16'sd200, 16'sd100, 0);
    drain();
    write_reg(REG_NUM_DRONES, 16'd2);
    send_wind(16'sd3, 16'sd2, -16'sd5, 0);
    drain();
    write_reg(REG_NUM_DRONES, 16'd31);
    repeat (17) send_wind(16'sd50, 16'sd60, -16'sd70, 1);
    drain();

    // Random phases, each with its own settings.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_DRONE_GAIN, (ph % 4 == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
      write_reg(REG_PAYLOAD_GAIN, (ph % 4 == 1) ? 16'd0 : 16'($urandom_range(0, 65535)));
      write_reg(REG_NUM_DRONES, (ph % 3 == 0) ? 16'd16 : 16'($urandom_range(0, 31)));
      write_reg(REG_DEAD_ZONE, (ph % 4 == 2) ? 16'd0 : 16'($urandom_range(0, 1023)));
      fast = (ph % 4 == 3);
      repeat (50) begin
        mode = $urandom_range(0, 3);
        send_wind(rand_axis(mode), rand_axis(mode), rand_axis(mode), fast);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_quadratic_drag_force_stream OK");
    end else begin
      $display("tb_quadratic_drag_force_stream NOT OK");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+design
design/qdf_pkg.sv
design/qdf_front.sv
design/qdf_fifo.sv
design/qdf_back.sv
design/quadratic_drag_force_stream.sv
dv/qdf_checker.sv
dv/tb_quadratic_drag_force_stream.sv
